// ----- hw/rtl/jsled_pkg.sv -----
// ----------------------------------------------------------------------------
// jsled_pkg
// Shared types, constants and helpers of the script literal escape decoder.
// ----------------------------------------------------------------------------
`default_nettype none
package jsled_pkg;

    // bytes one input byte can produce at most
    localparam int GROUP_BYTES  = 6;
    localparam int QUEUE_DEPTH  = 4;

    // one input byte worth of decoded output
    typedef struct packed {
        logic [GROUP_BYTES-1:0][7:0] data;
        logic [2:0]                  cnt;   // 0 means end marker only
        logic                        last;
    } t_group;

    // result of one UTF-8 encode (1 to 3 bytes)
    typedef struct packed {
        logic [1:0]      len;
        logic [2:0][7:0] b;
    } t_enc;

    function automatic t_enc enc16(input logic [20:0] code);
        t_enc        e;
        logic [15:0] c;
        c = code[15:0];
        e = '0;
        if (c < 16'h0080) begin
            e.len  = 2'd1;
            e.b[0] = c[7:0];
        end else if (c < 16'h0800) begin
            e.len  = 2'd2;
            e.b[0] = {3'b110, c[10:6]};
            e.b[1] = {2'b10, c[5:0]};
        end else begin
            e.len  = 2'd3;
            e.b[0] = {4'b1110, c[15:12]};
            e.b[1] = {2'b10, c[11:6]};
            e.b[2] = {2'b10, c[5:0]};
        end
        return e;
    endfunction

    // hex digit value, anything else counts as zero
    function automatic logic [3:0] nibble(input logic [7:0] b);
        logic [3:0] v;
        v = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)      v = 4'(b - 8'h30);
        else if (b >= 8'h61 && b <= 8'h66) v = 4'(b - 8'h57);
        else if (b >= 8'h41 && b <= 8'h46) v = 4'(b - 8'h37);
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/jsled_front.sv -----
// ----------------------------------------------------------------------------
// jsled_front
// Escape state machine: takes one body byte per cycle while i_accept is high
// and forms the group of decoded bytes that byte completes.
// ----------------------------------------------------------------------------
`default_nettype none
module jsled_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_in_byte,
    input  wire logic             i_ident_mode,
    input  wire logic             i_decode_enable,
    input  wire logic             i_last_byte,
    output jsled_pkg::t_group     o_group,
    output logic                  o_group_push
);
    import jsled_pkg::*;

    typedef enum logic [3:0] {
        PH_NORMAL, PH_ESC, PH_ESC_CR, PH_LS1, PH_LS2,
        PH_OCT_LO, PH_OCT_HI, PH_HEX, PH_ID_U, PH_UTF4
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [20:0] r_acc, n_acc;
    logic [2:0]  r_cnt, n_cnt;
    logic [15:0] r_held, n_held;

    logic [7:0][7:0] ob;
    logic [2:0]      oc;

    always_comb begin
        logic        do_plain;
        logic [7:0]  b;
        logic [20:0] d;
        t_enc        e;
        t_enc        e2;
        b        = i_in_byte;
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_held   = r_held;
        ob       = '0;
        oc       = 3'd0;
        do_plain = 1'b0;
        d        = '0;
        e        = '0;
        e2       = '0;

        if (!i_decode_enable) begin
            n_phase = PH_NORMAL;
            ob[oc] = b; oc = oc + 3'd1;
        end else begin
            case (r_phase)
                PH_ESC: begin
                    n_phase = PH_NORMAL;
                    n_acc   = '0;
                    n_cnt   = 3'd0;
                    case (b)
                        8'h0D: n_phase = PH_ESC_CR;
                        8'h0A: ;
                        8'hE2: n_phase = PH_LS1;
                        8'h78: begin n_cnt = 3'd2; n_phase = PH_HEX; end
                        8'h75: begin n_cnt = 3'd4; n_phase = PH_HEX; end
                        8'h62: begin ob[oc] = 8'h08; oc = oc + 3'd1; end
                        8'h74: begin ob[oc] = 8'h09; oc = oc + 3'd1; end
                        8'h6E: begin ob[oc] = 8'h0A; oc = oc + 3'd1; end
                        8'h76: begin ob[oc] = 8'h0B; oc = oc + 3'd1; end
                        8'h66: begin ob[oc] = 8'h0C; oc = oc + 3'd1; end
                        8'h72: begin ob[oc] = 8'h0D; oc = oc + 3'd1; end
                        default: begin
                            if (b inside {[8'h30:8'h37]}) begin
                                n_acc   = {18'd0, b[2:0]};
                                n_cnt   = 3'd1;
                                n_phase = (b <= 8'h33) ? PH_OCT_LO : PH_OCT_HI;
                            end else if (b >= 8'hF0) begin
                                n_held  = {8'd0, b};
                                n_acc   = {b[2:0], 18'd0};
                                n_cnt   = 3'd1;
                                n_phase = PH_UTF4;
                            end else begin
                                ob[oc] = b; oc = oc + 3'd1;
                            end
                        end
                    endcase
                end
                PH_ESC_CR: begin
                    n_phase = PH_NORMAL;
                    if (b != 8'h0A) do_plain = 1'b1;
                end
                PH_LS1: begin
                    if (b == 8'h80) begin
                        n_phase = PH_LS2;
                    end else begin
                        ob[oc] = 8'hE2; oc = oc + 3'd1;
                        do_plain = 1'b1;
                    end
                end
                PH_LS2: begin
                    if (b == 8'hA8 || b == 8'hA9) begin
                        n_phase = PH_NORMAL;
                    end else begin
                        ob[oc] = 8'hE2; oc = oc + 3'd1;
                        ob[oc] = 8'h80; oc = oc + 3'd1;
                        do_plain = 1'b1;
                    end
                end
                PH_OCT_LO, PH_OCT_HI: begin
                    if (b inside {[8'h30:8'h37]}) begin
                        n_acc = {r_acc[17:0], b[2:0]};
                        n_cnt = r_cnt + 3'd1;
                        if (r_phase == PH_OCT_HI) begin
                            ob[oc] = n_acc[7:0]; oc = oc + 3'd1;
                            n_phase = PH_NORMAL;
                        end else if (n_cnt >= 3'd3) begin
                            e = enc16(n_acc);
                            for (int j = 0; j < 3; j++) begin
                                if (j < int'(e.len)) begin
                                    ob[oc] = e.b[j]; oc = oc + 3'd1;
                                end
                            end
                            n_phase = PH_NORMAL;
                        end
                    end else begin
                        if (r_phase == PH_OCT_HI) begin
                            ob[oc] = r_acc[7:0]; oc = oc + 3'd1;
                        end else begin
                            e = enc16(r_acc);
                            for (int j = 0; j < 3; j++) begin
                                if (j < int'(e.len)) begin
                                    ob[oc] = e.b[j]; oc = oc + 3'd1;
                                end
                            end
                        end
                        do_plain = 1'b1;
                    end
                end
                PH_HEX: begin
                    n_acc = {r_acc[16:0], nibble(b)};
                    n_cnt = r_cnt - 3'd1;
                    if (n_cnt == 3'd0) begin
                        e = enc16(n_acc);
                        for (int j = 0; j < 3; j++) begin
                            if (j < int'(e.len)) begin
                                ob[oc] = e.b[j]; oc = oc + 3'd1;
                            end
                        end
                        n_phase = PH_NORMAL;
                    end
                end
                PH_ID_U: begin
                    n_acc   = '0;
                    n_cnt   = 3'd4;
                    n_phase = PH_HEX;
                end
                PH_UTF4: begin
                    if (r_cnt == 3'd1) begin
                        n_acc  = r_acc | {3'd0, b[5:0], 12'd0};
                        n_held = {r_held[7:0], b};
                        n_cnt  = 3'd2;
                    end else if (r_cnt == 3'd2) begin
                        n_acc = r_acc | {9'd0, b[5:0], 6'd0};
                        n_cnt = 3'd3;
                    end else begin
                        n_acc = r_acc | {15'd0, b[5:0]};
                        // surrogate pair, each half three bytes
                        d  = n_acc - 21'h10000;
                        e  = enc16({5'd0, 6'b110110, d[19:10]});
                        e2 = enc16({5'd0, 6'b110111, d[9:0]});
                        for (int j = 0; j < 3; j++) begin
                            ob[oc] = e.b[j]; oc = oc + 3'd1;
                        end
                        for (int j = 0; j < 3; j++) begin
                            ob[oc] = e2.b[j]; oc = oc + 3'd1;
                        end
                        n_phase = PH_NORMAL;
                    end
                end
                default: do_plain = 1'b1;
            endcase

            // ordinary byte, also after an abandoned escape
            if (do_plain) begin
                n_phase = PH_NORMAL;
                if (b == 8'h5C) begin
                    n_phase = i_ident_mode ? PH_ID_U : PH_ESC;
                end else if (!i_ident_mode && b >= 8'hF0) begin
                    n_held  = {8'd0, b};
                    n_acc   = {b[2:0], 18'd0};
                    n_cnt   = 3'd1;
                    n_phase = PH_UTF4;
                end else begin
                    ob[oc] = b; oc = oc + 3'd1;
                end
            end

            // end of literal: flush whatever is pending
            if (i_last_byte) begin
                case (n_phase)
                    PH_LS1: begin ob[oc] = 8'hE2; oc = oc + 3'd1; end
                    PH_LS2: begin
                        ob[oc] = 8'hE2; oc = oc + 3'd1;
                        ob[oc] = 8'h80; oc = oc + 3'd1;
                    end
                    PH_OCT_HI: begin ob[oc] = n_acc[7:0]; oc = oc + 3'd1; end
                    PH_OCT_LO, PH_HEX: begin
                        e = enc16(n_acc);
                        for (int j = 0; j < 3; j++) begin
                            if (j < int'(e.len)) begin
                                ob[oc] = e.b[j]; oc = oc + 3'd1;
                            end
                        end
                    end
                    PH_UTF4: begin
                        if (n_cnt == 3'd1) begin
                            ob[oc] = n_held[7:0]; oc = oc + 3'd1;
                        end else begin
                            ob[oc] = n_held[15:8]; oc = oc + 3'd1;
                            ob[oc] = n_held[7:0];  oc = oc + 3'd1;
                            if (n_cnt != 3'd2) begin
                                ob[oc] = b; oc = oc + 3'd1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end

        if (i_last_byte) begin
            n_phase = PH_NORMAL;
            n_acc   = '0;
            n_cnt   = 3'd0;
            n_held  = '0;
        end
    end

    // group handed to the queue
    always_comb begin
        for (int j = 0; j < GROUP_BYTES; j++) o_group.data[j] = ob[j];
        o_group.cnt  = oc;
        o_group.last = i_last_byte;
        o_group_push = i_accept && (oc != 3'd0 || i_last_byte);
    end

    // escape state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NORMAL;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_held  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_held  <= n_held;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/jsled_queue.sv -----
// ----------------------------------------------------------------------------
// jsled_queue
// Short queue of output groups between the decoder and the serializer.
// ----------------------------------------------------------------------------
`default_nettype none
module jsled_queue #(
    parameter int DEPTH = jsled_pkg::QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr,
    input  wire jsled_pkg::t_group i_wr_data,
    input  wire logic              i_rd,
    output jsled_pkg::t_group      o_rd_data,
    output logic                   o_full,
    output logic                   o_empty
);
    import jsled_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_group          r_mem [DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_count;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wp] <= i_wr_data;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            if (i_rd) r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            if (i_wr && !i_rd)      r_count <= r_count + CW'(1);
            else if (!i_wr && i_rd) r_count <= r_count - CW'(1);
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/jsled_back.sv -----
// ----------------------------------------------------------------------------
// jsled_back
// Serializer: head group into output register, a byte per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none
module jsled_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire jsled_pkg::t_group i_head,
    input  wire logic             i_head_valid,
    output logic                  o_head_pop,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic [7:0]            o_out_byte,
    output logic                  o_byte_valid,
    output logic                  o_run_last,
    output logic                  o_literal_end
);
    import jsled_pkg::*;

    logic       r_ov;
    logic [2:0] r_idx;
    logic [7:0] r_byte;
    logic       r_bv, r_rl, r_le;
    logic       load, fin;

    assign load       = i_head_valid && (!r_ov || i_pop);
    assign fin        = (i_head.cnt == 3'd0) || (r_idx == i_head.cnt - 3'd1);
    assign o_head_pop = load && fin;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_idx <= '0;
        end else begin
            if (load)       r_ov <= 1'b1;
            else if (i_pop) r_ov <= 1'b0;
            if (load) r_idx <= fin ? 3'd0 : r_idx + 3'd1;
        end
        if (load) begin
            r_byte <= (i_head.cnt == 3'd0) ? 8'd0 : i_head.data[r_idx];
            r_bv   <= (i_head.cnt != 3'd0);
            r_rl   <= fin;
            r_le   <= fin && i_head.last;
        end
    end

    assign o_empty       = !r_ov;
    assign o_out_byte    = r_byte;
    assign o_byte_valid  = r_bv;
    assign o_run_last    = r_rl;
    assign o_literal_end = r_le;

endmodule
`default_nettype wire

// ----- hw/rtl/js_literal_escape_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// js_literal_escape_decoder_unit
// Script literal body bytes in, CESU-8 decoded bytes out, queue-style ports.
// ----------------------------------------------------------------------------
// Path: each accepted input byte's group is written into the queue, then loaded
// into the output register once that register is empty or being popped.
// Throughput: one input byte per cycle while each byte yields at most one
// result and every result is popped; the output register drains one result
// per cycle while popped, so a byte with N results (N up to 6) takes N pops.
// Reset: synchronous active low; clears escape state, queue and output register.
`default_nettype none
module js_literal_escape_decoder_unit #(
    parameter int QDEPTH = jsled_pkg::QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_ident_mode,
    input  wire logic       i_decode_enable,
    input  wire logic       i_last_byte,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_out_byte,
    output logic            o_byte_valid,
    output logic            o_run_last,
    output logic            o_literal_end
);
    import jsled_pkg::*;

    t_group grp, head;
    logic   grp_push, head_pop, q_empty, accept;

    assign accept = push && !full;

    jsled_front u_front (
        .i_clk, .i_rst_n,
        .i_accept        (accept),
        .i_in_byte, .i_ident_mode, .i_decode_enable, .i_last_byte,
        .o_group         (grp),
        .o_group_push    (grp_push)
    );

    jsled_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk, .i_rst_n,
        .i_wr      (grp_push),
        .i_wr_data (grp),
        .i_rd      (head_pop),
        .o_rd_data (head),
        .o_full    (full),
        .o_empty   (q_empty)
    );

    jsled_back u_back (
        .i_clk, .i_rst_n,
        .i_head       (head),
        .i_head_valid (!q_empty),
        .o_head_pop   (head_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out_byte, .o_byte_valid, .o_run_last, .o_literal_end
    );

endmodule
`default_nettype wire

// ----- hw/rtl/jsled_checker.sv -----
// ----------------------------------------------------------------------------
// jsled_checker
// Port-level checks of the escape decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module jsled_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_byte_valid,
    input wire logic       o_run_last,
    input wire logic       o_literal_end
);
    // nothing waits right after reset
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result shown after reset");

    // an end marker is always the final result of a literal with a zero byte
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_byte_valid) |-> (o_run_last && o_literal_end && o_out_byte == 8'd0))
        else $error("malformed end marker");

    // literal end only ever closes a run
    a_end_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_literal_end) |-> o_run_last)
        else $error("literal end without run end");

    // a waiting result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_byte)))
        else $error("result changed while stalled");
endmodule

bind js_literal_escape_decoder_unit jsled_checker u_chk (
    .i_clk, .i_rst_n, .empty, .pop,
    .o_out_byte, .o_byte_valid, .o_run_last, .o_literal_end
);
`default_nettype wire

// ----- sim/tb_js_literal_escape_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// tb_js_literal_escape_decoder_unit
// Self-checking bench: string and identifier literal bodies are decoded by a
// local predictor and compared byte for byte against the block's output queue.
// ----------------------------------------------------------------------------
module tb_js_literal_escape_decoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [3:0] {
        ST_PLAIN, ST_BSLASH, ST_BS_CR, ST_LINE1, ST_LINE2,
        ST_OCT_LO, ST_OCT_HI, ST_HEX, ST_ID_U, ST_WIDE
    } t_dec_state;

    typedef struct packed {
        logic [7:0] data;
        logic       ident;
        logic       dec_en;
        logic       last;
    } t_body_byte;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       run_last;
        logic       lit_end;
    } t_out_byte;

    localparam int CYCLE_LIMIT = 200000;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [7:0] i_in_byte;
    logic       i_ident_mode;
    logic       i_decode_enable;
    logic       i_last_byte;
    logic       empty;
    logic       pop;
    logic [7:0] o_out_byte;
    logic       o_byte_valid;
    logic       o_run_last;
    logic       o_literal_end;

    js_literal_escape_decoder_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_in_byte       (i_in_byte),
        .i_ident_mode    (i_ident_mode),
        .i_decode_enable (i_decode_enable),
        .i_last_byte     (i_last_byte),
        .empty           (empty),
        .pop             (pop),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_run_last      (o_run_last),
        .o_literal_end   (o_literal_end)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    t_body_byte pending_bytes[$];
    t_out_byte  decoded_bytes[$];
    int         error_count;
    int         cycle_count;
    bit         stim_done;

    // decoder state mirror
    t_dec_state dst;
    logic [20:0] code;
    logic [2:0]  digits;
    logic [15:0] held;
    logic [7:0]  obuf[$];

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic logic [3:0] hex_val(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) return 4'(b - 8'h30);
        if (b >= 8'h61 && b <= 8'h66) return 4'(b - 8'h61 + 10);
        if (b >= 8'h41 && b <= 8'h46) return 4'(b - 8'h41 + 10);
        return 4'd0;
    endfunction

    task automatic put_utf8(input logic [20:0] cp);
        logic [15:0] c;
        c = cp[15:0];
        if (c < 16'h80) begin
            obuf.push_back(c[7:0]);
        end else if (c < 16'h800) begin
            obuf.push_back({3'b110, c[10:6]});
            obuf.push_back({2'b10, c[5:0]});
        end else begin
            obuf.push_back({4'b1110, c[15:12]});
            obuf.push_back({2'b10, c[11:6]});
            obuf.push_back({2'b10, c[5:0]});
        end
    endtask

    task automatic begin_wide(input logic [7:0] b);
        held   = {8'h00, b};
        code   = 21'(b[2:0]) << 18;
        digits = 3'd1;
        dst    = ST_WIDE;
    endtask

    task automatic take_plain(input logic [7:0] b, input logic ident);
        dst = ST_PLAIN;
        if (b == 8'h5c) dst = ident ? ST_ID_U : ST_BSLASH;
        else if (!ident && b >= 8'hf0) begin_wide(b);
        else obuf.push_back(b);
    endtask

    task automatic take_escaped(input logic [7:0] b);
        dst    = ST_PLAIN;
        code   = '0;
        digits = '0;
        case (b)
            8'h0d: dst = ST_BS_CR;
            8'h0a: ;
            8'he2: dst = ST_LINE1;
            8'h78: begin digits = 3'd2; dst = ST_HEX; end
            8'h75: begin digits = 3'd4; dst = ST_HEX; end
            8'h62: obuf.push_back(8'h08);
            8'h74: obuf.push_back(8'h09);
            8'h6e: obuf.push_back(8'h0a);
            8'h76: obuf.push_back(8'h0b);
            8'h66: obuf.push_back(8'h0c);
            8'h72: obuf.push_back(8'h0d);
            default: begin
                if (b >= 8'h30 && b <= 8'h37) begin
                    code   = 21'(b - 8'h30);
                    digits = 3'd1;
                    dst    = (b <= 8'h33) ? ST_OCT_LO : ST_OCT_HI;
                end else if (b >= 8'hf0) begin
                    begin_wide(b);
                end else begin
                    obuf.push_back(b);
                end
            end
        endcase
    endtask

    task automatic predict_byte(input t_body_byte t);
        logic [20:0] d;
        logic [7:0]  b;
        t_out_byte   r;
        b = t.data;
        obuf.delete();
        if (!t.dec_en) begin
            dst = ST_PLAIN;
            obuf.push_back(b);
        end else begin
            case (dst)
                ST_BSLASH: take_escaped(b);
                ST_BS_CR: begin
                    dst = ST_PLAIN;
                    if (b != 8'h0a) take_plain(b, t.ident);
                end
                ST_LINE1: begin
                    if (b == 8'h80) dst = ST_LINE2;
                    else begin obuf.push_back(8'he2); take_plain(b, t.ident); end
                end
                ST_LINE2: begin
                    if (b == 8'ha8 || b == 8'ha9) dst = ST_PLAIN;
                    else begin
                        obuf.push_back(8'he2);
                        obuf.push_back(8'h80);
                        take_plain(b, t.ident);
                    end
                end
                ST_OCT_LO, ST_OCT_HI: begin
                    if (b >= 8'h30 && b <= 8'h37) begin
                        code   = 21'(code * 8 + (b - 8'h30));
                        digits = digits + 3'd1;
                        if (dst == ST_OCT_HI) begin
                            obuf.push_back(code[7:0]);
                            dst = ST_PLAIN;
                        end else if (digits >= 3) begin
                            put_utf8(code);
                            dst = ST_PLAIN;
                        end
                    end else begin
                        if (dst == ST_OCT_HI) obuf.push_back(code[7:0]);
                        else put_utf8(code);
                        take_plain(b, t.ident);
                    end
                end
                ST_HEX: begin
                    code   = {code[16:0], hex_val(b)};
                    digits = digits - 3'd1;
                    if (digits == 0) begin
                        put_utf8(code);
                        dst = ST_PLAIN;
                    end
                end
                ST_ID_U: begin
                    code   = '0;
                    digits = 3'd4;
                    dst    = ST_HEX;
                end
                ST_WIDE: begin
                    if (digits == 1) begin
                        code   = code | (21'(b[5:0]) << 12);
                        held   = {held[7:0], b};
                        digits = 3'd2;
                    end else if (digits == 2) begin
                        code   = code | (21'(b[5:0]) << 6);
                        digits = 3'd3;
                    end else begin
                        code = code | 21'(b[5:0]);
                        d    = code - 21'h10000;
                        put_utf8(21'h0d800 | 21'(d[19:10]));
                        put_utf8(21'h0dc00 | 21'(d[9:0]));
                        dst = ST_PLAIN;
                    end
                end
                default: take_plain(b, t.ident);
            endcase
            // flush whatever is pending at the end of the literal
            if (t.last) begin
                case (dst)
                    ST_LINE1: obuf.push_back(8'he2);
                    ST_LINE2: begin obuf.push_back(8'he2); obuf.push_back(8'h80); end
                    ST_OCT_LO, ST_HEX: put_utf8(code);
                    ST_OCT_HI: obuf.push_back(code[7:0]);
                    ST_WIDE: begin
                        if (digits == 1) begin
                            obuf.push_back(held[7:0]);
                        end else begin
                            obuf.push_back(held[15:8]);
                            obuf.push_back(held[7:0]);
                            if (digits != 2) obuf.push_back(b);
                        end
                    end
                    default: ;
                endcase
            end
        end
        if (t.last) begin
            dst    = ST_PLAIN;
            code   = '0;
            digits = '0;
            held   = '0;
        end
        if (obuf.size() == 0) begin
            if (t.last) decoded_bytes.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
        end else begin
            foreach (obuf[k]) begin
                r.data     = obuf[k];
                r.valid    = 1'b1;
                r.run_last = (k == obuf.size() - 1);
                r.lit_end  = r.run_last && t.last;
                decoded_bytes.push_back(r);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic add_literal(input logic ident, input logic dec_en,
                               input logic [7:0] body[$]);
        t_body_byte t;
        foreach (body[k]) begin
            t.data   = body[k];
            t.ident  = ident;
            t.dec_en = dec_en;
            t.last   = (k == body.size() - 1);
            pending_bytes.push_back(t);
        end
    endtask

    function automatic logic [7:0] rand_hex();
        case ($urandom_range(0, 3))
            0: return 8'(8'h30 + $urandom_range(0, 9));
            1: return 8'(8'h61 + $urandom_range(0, 5));
            2: return 8'(8'h41 + $urandom_range(0, 5));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_random_literal();
        logic [7:0] body[$];
        logic       ident;
        logic       dec_en;
        int         n;
        int         kind;
        ident  = ($urandom_range(0, 3) == 0);
        dec_en = ($urandom_range(0, 7) != 0);
        n      = $urandom_range(1, 4);
        repeat (n) begin
            kind = $urandom_range(0, 11);
            case (kind)
                0: body.push_back(8'($urandom_range(0, 255)));
                1: body.push_back(8'($urandom_range(8'h20, 8'h7e)));
                2: begin
                    body.push_back(8'h5c);
                    body.push_back(8'($urandom_range(0, 255)));
                end
                3: begin
                    body.push_back(8'h5c);
                    body.push_back(8'h75);
                    repeat ($urandom_range(1, 4)) body.push_back(rand_hex());
                end
                4: begin
                    body.push_back(8'h5c);
                    body.push_back(8'h78);
                    repeat ($urandom_range(1, 2)) body.push_back(rand_hex());
                end
                5: begin
                    body.push_back(8'h5c);
                    repeat ($urandom_range(1, 4))
                        body.push_back(8'(8'h30 + $urandom_range(0, 9)));
                end
                6: begin
                    body.push_back(8'($urandom_range(8'hf0, 8'hff)));
                    repeat ($urandom_range(0, 3))
                        body.push_back(8'($urandom_range(8'h80, 8'hbf)));
                end
                7: begin
                    body.push_back(8'h5c);
                    body.push_back(8'he2);
                    if ($urandom_range(0, 3) != 0) body.push_back(8'h80);
                    if ($urandom_range(0, 3) != 0)
                        body.push_back(8'(8'ha8 + $urandom_range(0, 2)));
                end
                8: begin
                    body.push_back(8'h5c);
                    body.push_back(8'h0d);
                    if ($urandom_range(0, 1)) body.push_back(8'h0a);
                end
                9: begin
                    body.push_back(8'h5c);
                    body.push_back(8'($urandom_range(8'hf0, 8'hff)));
                    repeat ($urandom_range(1, 3))
                        body.push_back(8'($urandom_range(0, 255)));
                end
                10: begin
                    body.push_back(8'h5c);
                    case ($urandom_range(0, 5))
                        0: body.push_back(8'h62);
                        1: body.push_back(8'h74);
                        2: body.push_back(8'h6e);
                        3: body.push_back(8'h76);
                        4: body.push_back(8'h66);
                        default: body.push_back(8'h72);
                    endcase
                end
                default: body.push_back(8'h5c);
            endcase
        end
        // a few literals flip mode or decoding midway
        if ($urandom_range(0, 9) == 0) begin
            add_literal(ident, dec_en, body);
            pending_bytes[pending_bytes.size() - 1].last = 1'b0;
            body.delete();
            body.push_back(8'($urandom_range(0, 255)));
            add_literal(!ident, 1'($urandom_range(0, 1)), body);
        end else begin
            add_literal(ident, dec_en, body);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("ERROR t=%0t %s: got %02h expected %02h", $realtime, what, got, want);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // driver: bursts with random gaps
    // ------------------------------------------------------------------------
    int   burst_left;
    int   gap_left;
    logic full_at_edge;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full_at_edge) begin
                // previous transaction accepted at last rising edge
            end
            if (pending_bytes.size() == 0) begin
                push <= 1'b0;
            end else if (push && full_at_edge) begin
                push <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
                push <= 1'b0;
            end else begin
                i_in_byte       <= pending_bytes[0].data;
                i_ident_mode    <= pending_bytes[0].ident;
                i_decode_enable <= pending_bytes[0].dec_en;
                i_last_byte     <= pending_bytes[0].last;
                push            <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 20);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // acceptance at the rising edge
    always @(posedge i_clk) begin
        full_at_edge <= full;
        if (i_rst_n && push && !full) begin
            predict_byte(pending_bytes.pop_front());
        end
    end

    // receiver stall pattern
    logic [15:0] stall_lfsr;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop        <= 1'b0;
            stall_lfsr <= 16'hace1;
        end else begin
            stall_lfsr <= {stall_lfsr[14:0],
                           stall_lfsr[15] ^ stall_lfsr[13] ^ stall_lfsr[12] ^ stall_lfsr[10]};
            if (cycle_count[9]) pop <= 1'b1;
            else pop <= (stall_lfsr[2:0] != 3'b000) && (stall_lfsr[7:5] != 3'b111);
        end
    end

    // ------------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_byte w;
        if (i_rst_n && pop && !empty) begin
            if (decoded_bytes.size() == 0) begin
                report_mismatch("unexpected transaction", o_out_byte, 8'h00);
            end else begin
                w = decoded_bytes.pop_front();
                if (o_out_byte !== w.data)
                    report_mismatch("out_byte", o_out_byte, w.data);
                if (o_byte_valid !== w.valid)
                    report_mismatch("byte_valid", 8'(o_byte_valid), 8'(w.valid));
                if (o_run_last !== w.run_last)
                    report_mismatch("run_last", 8'(o_run_last), 8'(w.run_last));
                if (o_literal_end !== w.lit_end)
                    report_mismatch("literal_end", 8'(o_literal_end), 8'(w.lit_end));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [7:0] b[$];
        push            = 1'b0;
        pop             = 1'b0;
        i_in_byte       = 8'h00;
        i_ident_mode    = 1'b0;
        i_decode_enable = 1'b0;
        i_last_byte     = 1'b0;
        full_at_edge    = 1'b0;
        stall_lfsr      = 16'hace1;
        error_count     = 0;
        cycle_count     = 0;
        burst_left      = 0;
        gap_left        = 0;
        dst             = ST_PLAIN;
        code            = '0;
        digits          = '0;
        held            = '0;
        i_rst_n         = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b0;
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, control escapes, line breaks, cut-short cases
        b = '{8'h00, 8'hff};                   add_literal(1'b0, 1'b0, b);
        b = '{8'h5c, 8'h62, 8'h5c, 8'h72};     add_literal(1'b0, 1'b1, b);
        b = '{8'h5c, 8'h75, 8'h46, 8'h66, 8'h30, 8'h7a};
        add_literal(1'b0, 1'b1, b);
        b = '{8'h5c, 8'h33, 8'h37, 8'h37};     add_literal(1'b0, 1'b1, b);
        b = '{8'h5c, 8'h37, 8'h37, 8'h41};     add_literal(1'b0, 1'b1, b);
        b = '{8'hf4, 8'h8f, 8'hbf, 8'hbf};     add_literal(1'b0, 1'b1, b);
        b = '{8'h5c, 8'he2, 8'h80, 8'ha9, 8'h5c, 8'h0d, 8'h0a, 8'h5c};
        add_literal(1'b0, 1'b1, b);
        b = '{8'h5c, 8'h75, 8'h31, 8'h32, 8'h33, 8'h34};
        add_literal(1'b1, 1'b1, b);
        b = '{8'h5c, 8'h78, 8'h41};            add_literal(1'b0, 1'b1, b);
        b = '{8'hf0, 8'h90};                   add_literal(1'b0, 1'b1, b);
        b = '{8'h5c, 8'he2, 8'h80};            add_literal(1'b0, 1'b1, b);

        // random literals
        while (pending_bytes.size() < 310) add_random_literal();
        stim_done = 1'b1;

        wait (pending_bytes.size() == 0);
        wait (decoded_bytes.size() == 0);
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
